FILE: rtl/core/b64cc_pkg.sv
// Shared types, constants and the base64 alphabet decode for the chunk collector.
// No dependencies; imported by every module under rtl/core.
package b64cc_pkg;

   // sizing of the cover memory
   localparam int MAX_COVER_BYTES = 262144;
   localparam int CAPACITY_MARGIN = 256;
   localparam int ADDR_W          = 19;
   localparam int SIZE_W          = 20;
   localparam int ACC_W           = 12;
   localparam int PEND_W          = 3;
   localparam int SEXTET_W        = 6;
   localparam int BYTE_W          = 8;
   localparam int NEED_W          = SIZE_W + 1;

   // beat layouts
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USED_W = 1 + ADDR_W + BYTE_W + 1 + 1 + ADDR_W;

   // sextet values of the two punctuation characters
   localparam logic [SEXTET_W-1:0] SEXTET_PLUS  = 6'd62;
   localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 6'd63;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_CHAR  = 2'd1,
      ACT_BOUND = 2'd2,
      ACT_END   = 2'd3
   } action_type;

   // classified item handed from front to back
   typedef struct packed {
      action_type                act;
      logic                      sextet_ok;
      logic [SEXTET_W-1:0]       sextet;
      logic                      size_ok;
      logic [ADDR_W-1:0]         need;
   } cmd_type;

   // one result beat
   typedef struct packed {
      logic [ADDR_W-1:0] byte_count;
      logic              collecting;
      logic              cover_ready;
      logic [BYTE_W-1:0] write_byte;
      logic [ADDR_W-1:0] write_addr;
      logic              write_valid;
   } rsp_type;

   typedef struct packed {
      logic                ok;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'; anything else is not ok
   function automatic sextet_type decode_sextet(input logic [BYTE_W-1:0] ch);
      sextet_type r;
      r.ok    = 1'b1;
      r.value = '0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         r.value = SEXTET_W'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         r.value = SEXTET_W'(ch - 8'h61 + 8'd26);
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         r.value = SEXTET_W'(ch - 8'h30 + 8'd52);
      end else if (ch == 8'h2B) begin
         r.value = SEXTET_PLUS;
      end else if (ch == 8'h2F) begin
         r.value = SEXTET_SLASH;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/b64cc_front.sv
// Front end: classifies an incoming beat (alphabet decode, size check, capacity need).
// Depends on b64cc_pkg.
module b64cc_front (
   input  logic [1:0]                           action,
   input  logic [b64cc_pkg::BYTE_W-1:0]         character,
   input  logic [b64cc_pkg::SIZE_W-1:0]         announced_size,
   output b64cc_pkg::cmd_type                   cmd
);
   import b64cc_pkg::*;

   sextet_type          sx;
   logic [NEED_W-1:0]   size_wide;
   logic [NEED_W-1:0]   need_wide;

   // alphabet lookup
   assign sx = decode_sextet(character);

   // size check and capacity need
   assign size_wide = {1'b0, announced_size};
   assign need_wide = size_wide + NEED_W'(CAPACITY_MARGIN);

   always_comb begin
      cmd.act       = action_type'(action);
      cmd.sextet_ok = sx.ok;
      cmd.sextet    = sx.value;
      cmd.size_ok   = (announced_size != '0) && (size_wide <= NEED_W'(MAX_COVER_BYTES));
      cmd.need      = need_wide[ADDR_W-1:0];
   end

endmodule

FILE: rtl/core/b64cc_queue.sv
// Two-entry queue of classified commands between front and back.
// Depends on b64cc_pkg.
module b64cc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64cc_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               avail,
   output b64cc_pkg::cmd_type head_cmd
);
   import b64cc_pkg::*;

   cmd_type     entries_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full     = count_ff[1];
   assign avail    = count_ff != '0;
   assign head_cmd = entries_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/b64cc_back.sv
// Back end: collector state, bit accumulator and the registered result beat.
// Depends on b64cc_pkg.
module b64cc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               avail,
   input  b64cc_pkg::cmd_type cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b64cc_pkg::rsp_type rsp
);
   import b64cc_pkg::*;

   logic              coll_ff, coll_in;
   logic [ADDR_W-1:0] cap_ff, cap_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic [3:0]        bits;
   logic [ACC_W-1:0]  acc_shifted;
   logic [ACC_W-1:0]  byte_src;

   // take a command whenever the result register is free or draining
   assign pop = avail && (!out_valid_ff || rsp_ready);

   // accumulator arithmetic for a character
   always_comb begin
      bits        = 4'(pend_ff) + 4'd6;
      acc_shifted = {acc_ff[ACC_W-SEXTET_W-1:0], cmd.sextet};
      byte_src    = acc_shifted >> (bits - 4'd8);
   end

   // command execution
   always_comb begin
      coll_in = coll_ff;
      cap_in  = cap_ff;
      len_in  = len_ff;
      acc_in  = acc_ff;
      pend_in = pend_ff;
      out_in  = '0;
      unique case (cmd.act)
         ACT_START: begin
            acc_in  = '0;
            pend_in = '0;
            if (!cmd.size_ok) begin
               coll_in = 1'b0;
            end else begin
               if (cap_ff < cmd.need) cap_in = cmd.need;
               len_in  = '0;
               coll_in = 1'b1;
            end
         end
         ACT_CHAR: begin
            if (coll_ff && cmd.sextet_ok) begin
               acc_in = acc_shifted;
               if (bits >= 4'd8) begin
                  pend_in = PEND_W'(bits - 4'd8);
                  if (len_ff < cap_ff) begin
                     out_in.write_valid = 1'b1;
                     out_in.write_addr  = len_ff;
                     out_in.write_byte  = byte_src[BYTE_W-1:0];
                     len_in             = len_ff + 1'b1;
                  end
               end else begin
                  pend_in = PEND_W'(bits);
               end
            end
         end
         ACT_BOUND: begin
            acc_in  = '0;
            pend_in = '0;
         end
         ACT_END: begin
            acc_in  = '0;
            pend_in = '0;
            out_in.cover_ready = coll_ff && (len_ff != '0);
            coll_in = 1'b0;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
      out_in.collecting = coll_in;
      out_in.byte_count = len_in;
      out_valid_in = pop ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         coll_ff      <= 1'b0;
         cap_ff       <= '0;
         len_ff       <= '0;
         acc_ff       <= '0;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            coll_ff <= coll_in;
            cap_ff  <= cap_in;
            len_ff  <= len_in;
            acc_ff  <= acc_in;
            pend_ff <= pend_in;
         end
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (pop) out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // held bit count only ever takes even values
   a_pend_even: assert property (@(posedge clock) disable iff (reset)
      pend_ff[0] == 1'b0) else $error("odd pending bit count");

   // length never passes capacity
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      len_ff <= cap_ff) else $error("length above capacity");

   // a written byte advances the reported count by one
   a_write_count: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.write_valid) |->
      (out_ff.byte_count == out_ff.write_addr + 1'b1))
      else $error("byte count does not follow write address");

   // ready and write never share a beat
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.cover_ready && out_ff.write_valid))
      else $error("cover ready alongside a write");

endmodule

FILE: rtl/core/base64_chunk_collector_unit.sv
// Base64 chunk collector: decodes chunked base64 text into cover-memory writes.
// Path: beats pass a two-entry queue, then a response register; these decouple the two sides.
// Throughput: one beat per cycle while rsp_tready stays high.
// Reset: synchronous, active high; clears collecting state, capacity, length and accumulator.
// Depends on b64cc_pkg, b64cc_front, b64cc_queue, b64cc_back.
module base64_chunk_collector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] character, [27:8] announced_size, [31:28] zero
   input  logic [b64cc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] action
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] write_valid, [19:1] write_addr, [27:20] write_byte, [28] cover_ready,
   // [29] collecting, [48:30] byte_count, [55:49] zero
   output logic [b64cc_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import b64cc_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   rsp_type rsp;
   logic    q_full;
   logic    q_avail;
   logic    q_pop;
   logic    q_push;

   // classify the request beat
   b64cc_front u_front (
      .action         (req_tuser),
      .character      (req_tdata[BYTE_W-1:0]),
      .announced_size (req_tdata[BYTE_W+SIZE_W-1:BYTE_W]),
      .cmd            (front_cmd)
   );

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   b64cc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .avail    (q_avail),
      .head_cmd (head_cmd)
   );

   b64cc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .avail     (q_avail),
      .cmd       (head_cmd),
      .pop       (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the response beat
   assign rsp_tdata = {(RSP_DATA_W-RSP_USED_W)'(0), rsp};

endmodule

FILE: verif/base64_chunk_collector_monitor.sv
// Monitor for the base64 chunk collector: predicts each response beat and checks it.
// Watches both stream channels of base64_chunk_collector_unit; depends on b64cc_pkg.
`timescale 1ns / 1ps

module base64_chunk_collector_monitor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [b64cc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [b64cc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               beats_checked,
   output int                               bytes_written,
   output int                               bytes_dropped,
   output int                               covers_ready
);
   import b64cc_pkg::*;

   // predicted collector state
   logic              is_collecting;
   logic [ADDR_W-1:0] cap_bytes;
   logic [ADDR_W-1:0] length_bytes;
   logic [ACC_W-1:0]  acc_bits;
   logic [PEND_W-1:0] acc_fill;

   // response beats still owed by the block, oldest first
   rsp_type predicted_beats[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      beats_checked = 0;
      bytes_written = 0;
      bytes_dropped = 0;
      covers_ready  = 0;
   end

   // alphabet value of a text byte, -1 when outside the alphabet
   function automatic int sextet_lookup(input logic [BYTE_W-1:0] ch);
      if (ch >= "A" && ch <= "Z") return int'(ch) - int'("A");
      if (ch >= "a" && ch <= "z") return int'(ch) - int'("a") + 26;
      if (ch >= "0" && ch <= "9") return int'(ch) - int'("0") + 52;
      if (ch == "+") return 62;
      if (ch == "/") return 63;
      return -1;
   endfunction

   // advance the predicted state by one request beat, return its response
   function automatic rsp_type decode_and_collect(input action_type act,
                                                  input logic [BYTE_W-1:0] ch,
                                                  input logic [SIZE_W-1:0] size);
      rsp_type r;
      int      sx;
      int      fill;
      r  = '0;
      sx = 0;
      case (act)
         ACT_START: begin
            acc_bits = '0;
            acc_fill = '0;
            if (size == 0 || size > MAX_COVER_BYTES) begin
               is_collecting = 1'b0;
            end else begin
               if (cap_bytes < size + CAPACITY_MARGIN)
                  cap_bytes = ADDR_W'(size + CAPACITY_MARGIN);
               length_bytes  = '0;
               is_collecting = 1'b1;
            end
         end
         ACT_CHAR: begin
            sx = sextet_lookup(ch);
            if (is_collecting && sx >= 0) begin
               fill     = int'(acc_fill) + SEXTET_W;
               acc_bits = {acc_bits[ACC_W-SEXTET_W-1:0], sx[SEXTET_W-1:0]};
               if (fill >= BYTE_W) begin
                  fill -= BYTE_W;
                  if (length_bytes < cap_bytes) begin
                     r.write_valid = 1'b1;
                     r.write_addr  = length_bytes;
                     r.write_byte  = BYTE_W'(acc_bits >> fill);
                     length_bytes  = length_bytes + 1'b1;
                  end else begin
                     // buffer full: byte leaves the accumulator unwritten
                     bytes_dropped++;
                  end
               end
               acc_fill = PEND_W'(fill);
            end
         end
         ACT_BOUND: begin
            acc_bits = '0;
            acc_fill = '0;
         end
         ACT_END: begin
            acc_bits      = '0;
            acc_fill      = '0;
            r.cover_ready = is_collecting && (length_bytes != 0);
            is_collecting = 1'b0;
         end
      endcase
      r.collecting = is_collecting;
      r.byte_count = length_bytes;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // responses are checked before the same edge's request is predicted
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         is_collecting = 1'b0;
         cap_bytes     = '0;
         length_bytes  = '0;
         acc_bits      = '0;
         acc_fill      = '0;
         predicted_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_beats.size() == 0) begin
               $error("response beat with no request outstanding: 0x%0h", rsp_tdata);
               fail_count++;
            end else begin
               want = predicted_beats.pop_front();
               got  = rsp_type'(rsp_tdata[RSP_USED_W-1:0]);
               check_field("write_valid", want.write_valid, got.write_valid);
               check_field("write_addr", want.write_addr, got.write_addr);
               check_field("write_byte", want.write_byte, got.write_byte);
               check_field("cover_ready", want.cover_ready, got.cover_ready);
               check_field("collecting", want.collecting, got.collecting);
               check_field("byte_count", want.byte_count, got.byte_count);
               check_field("tdata pad", 0, rsp_tdata[RSP_DATA_W-1:RSP_USED_W]);
               beats_checked++;
               if (want.write_valid) bytes_written++;
               if (want.cover_ready) covers_ready++;
            end
         end
         if (req_tvalid && req_tready)
            predicted_beats.push_back(decode_and_collect(action_type'(req_tuser),
                                                         req_tdata[BYTE_W-1:0],
                                                         req_tdata[BYTE_W+SIZE_W-1:BYTE_W]));
      end
      pending_count <= predicted_beats.size();
   end

endmodule

FILE: verif/base64_chunk_collector_unit_test.sv
// Testbench top for base64_chunk_collector_unit: clock, reset, request stimulus and verdict.
// Depends on b64cc_pkg, the block under test and base64_chunk_collector_monitor.
`timescale 1ns / 1ps

module base64_chunk_collector_unit_test;
   import b64cc_pkg::*;

   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 40;
   localparam int LINE_CHARS     = 76;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [7:0] character, [27:8] announced_size, [31:28] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // [1:0] action
   logic [1:0]            req_tuser  = ACT_START;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] write_valid, [19:1] write_addr, [27:20] write_byte, [28] cover_ready,
   // [29] collecting, [48:30] byte_count, [55:49] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int beats_checked;
   int bytes_written;
   int bytes_dropped;
   int covers_ready;

   bit quiet_phase = 1'b0;
   int useful_beats = 0;
   int stall_cycles = 0;
   int rsp_wait = 0;
   int rsp_draw;

   base64_chunk_collector_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   base64_chunk_collector_monitor monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .beats_checked (beats_checked),
      .bytes_written (bytes_written),
      .bytes_dropped (bytes_dropped),
      .covers_ready  (covers_ready)
   );

   // 4 ns clock
   always #2 clock = ~clock;

   // idle cycles before the next beat on either side
   function automatic int draw_gap();
      if (quiet_phase) return 0;
      return $urandom_range(0, 16);
   endfunction

   function automatic logic [BYTE_W-1:0] base64_char(input int v);
      if (v < 26) return BYTE_W'(int'("A") + v);
      if (v < 52) return BYTE_W'(int'("a") + v - 26);
      if (v < 62) return BYTE_W'(int'("0") + v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   // response side back-pressure, one stall drawn per accepted beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_draw = draw_gap();
         rsp_tready <= (rsp_draw == 0);
         rsp_wait   <= rsp_draw;
      end else if (!rsp_tready) begin
         if (rsp_wait <= 1) rsp_tready <= 1'b1;
         rsp_wait <= rsp_wait - 1;
      end
   end

   // watchdog on cycles where neither channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", stall_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // present one request beat, hold it until taken, then idle for a drawn gap
   task automatic send_beat(input action_type act, input logic [BYTE_W-1:0] ch,
                            input logic [SIZE_W-1:0] size, input bit counts);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_DATA_W - SIZE_W - BYTE_W){1'b0}}, size, ch};
      do @(posedge clock); while (!req_tready);
      if (counts) useful_beats++;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_char(input logic [BYTE_W-1:0] ch, input bit counts);
      send_beat(ACT_CHAR, ch, SIZE_W'($urandom), counts);
   endtask

   // one text line: mostly alphabet, some padding and stray bytes
   task automatic send_line(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) send_char("=", 1'b0);
         else if (pick == 1) send_char(BYTE_W'($urandom_range(0, 255)), 1'b0);
         else send_char(base64_char($urandom_range(0, 63)), 1'b1);
      end
   endtask

   // start, a few lines each closed by a boundary, usually an end
   task automatic random_cover();
      logic [SIZE_W-1:0] size;
      int                nlines;
      quiet_phase = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
         0: size = ($urandom_range(0, 1) == 0) ? '0 :
                   SIZE_W'($urandom_range(MAX_COVER_BYTES + 1, (1 << SIZE_W) - 1));
         1: size = SIZE_W'(MAX_COVER_BYTES);
         2: size = SIZE_W'($urandom_range(1, MAX_COVER_BYTES));
         default: size = SIZE_W'($urandom_range(1, 600));
      endcase
      send_beat(ACT_START, BYTE_W'($urandom), size, 1'b1);
      nlines = $urandom_range(0, 4);
      repeat (nlines) begin
         send_line($urandom_range(1, 40));
         send_beat(ACT_BOUND, BYTE_W'($urandom), SIZE_W'($urandom), 1'b1);
      end
      if ($urandom_range(0, 7) != 0)
         send_beat(ACT_END, BYTE_W'($urandom), SIZE_W'($urandom), 1'b1);
   endtask

   // fully random beats between covers
   task automatic send_noise();
      action_type act;
      repeat ($urandom_range(1, 3)) begin
         act = action_type'($urandom_range(0, 3));
         send_beat(act, BYTE_W'($urandom_range(0, 255)),
                   SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)), act != ACT_CHAR);
      end
   endtask

   initial begin
      int start_items;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: idle handling and rejected sizes
      send_beat(ACT_END, 8'h00, '0, 1'b1);
      send_char("Q", 1'b1);
      send_beat(ACT_START, 8'hFF, '0, 1'b1);
      send_beat(ACT_START, 8'h00, SIZE_W'(MAX_COVER_BYTES + 1), 1'b1);
      send_beat(ACT_START, 8'h00, {SIZE_W{1'b1}}, 1'b1);
      // end right after start, nothing collected
      send_beat(ACT_START, 8'h00, SIZE_W'(1), 1'b1);
      send_beat(ACT_END, 8'h00, '0, 1'b1);
      // decode with skipped bytes mixed in, punctuation sextets, mid-line boundary
      send_beat(ACT_START, 8'h00, SIZE_W'(1), 1'b1);
      send_char("T", 1'b1);
      send_char("=", 1'b1);
      send_char("W", 1'b1);
      send_char(8'h00, 1'b1);
      send_char("F", 1'b1);
      send_char(8'hFF, 1'b1);
      send_char("u", 1'b1);
      send_char("+", 1'b1);
      send_char("/", 1'b1);
      send_char("/", 1'b1);
      send_char("+", 1'b1);
      send_char("z", 1'b1);
      send_beat(ACT_BOUND, 8'h00, '0, 1'b1);
      send_char("a", 1'b1);
      send_char("9", 1'b1);
      send_beat(ACT_END, 8'h00, '0, 1'b1);
      // rejected start while collecting keeps the length
      send_beat(ACT_START, 8'h00, SIZE_W'(2), 1'b1);
      send_char("0", 1'b1);
      send_char("z", 1'b1);
      send_beat(ACT_START, 8'h00, '0, 1'b1);
      send_char("A", 1'b1);

      // fill the small capacity until bytes get dropped
      send_beat(ACT_START, BYTE_W'($urandom), SIZE_W'(1), 1'b1);
      repeat (5) begin
         repeat (LINE_CHARS) send_char(base64_char($urandom_range(0, 63)), 1'b1);
         send_beat(ACT_BOUND, BYTE_W'($urandom), SIZE_W'($urandom), 1'b1);
      end
      send_beat(ACT_END, BYTE_W'($urandom), SIZE_W'($urandom), 1'b1);

      // random covers with random content
      start_items = useful_beats;
      while (useful_beats - start_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         random_cover();
      end
      req_tvalid <= 1'b0;

      // let the owed count catch up with the last accepted beat
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("sent %0d decoding beats; checked %0d responses", useful_beats, beats_checked);
      $display("%0d bytes written, %0d dropped when full, %0d covers ready",
               bytes_written, bytes_dropped, covers_ready);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
